@@ hdl/icrt_pkg.sv @@
`default_nettype none
package icrt_pkg;

	localparam int DEF_TABLE_SLOTS       = 64;
	localparam int DEF_INODES_PER_SECTOR = 16;
	localparam int DEF_INODE_BYTES       = 32;

	localparam int OP_W   = 2;
	localparam int DEV_W  = 16;
	localparam int INO_W  = 12;
	localparam int SLOT_W = 6;
	localparam int STAT_W = 3;
	localparam int SEC_W  = 17;
	localparam int BOFF_W = 9;
	localparam int CNT_W  = 8;
	localparam int IMS_W  = 8;
	localparam int SMS_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// boot sector plus super block
	localparam int BOOT_SECTORS = 1 + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_SYNC    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE        = 3'd0,
		ST_FETCH       = 3'd1,
		ST_NULL        = 3'd2,
		ST_FULL        = 3'd3,
		ST_UNKNOWN_DEV = 3'd4,
		ST_UNUSED      = 3'd5,
		ST_LIMIT       = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOT_DEVICE  = 2'd0,
		CFG_INODE_MAP    = 2'd1,
		CFG_SECTOR_MAP   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic [INO_W-1:0] inode;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    scan_step;
		logic    mem_wr;
		logic    calc_q;
		logic    calc_r;
		logic    finish;
		status_t status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic num_zero;
		logic si_bad;
		logic scan_last;
		logic hit_found;
		logic hit_at_max;
		logic free_found;
		logic dev_root;
	} sts_t;

endpackage
`default_nettype wire

@@ hdl/icrt_ctrl.sv @@
`default_nettype none
module icrt_ctrl
	import icrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_SCAN     = 9'b000000100,
		S_SCAN_END = 9'b000001000,
		S_DECIDE   = 9'b000010000,
		S_FETCH    = 9'b000100000,
		S_CALC_Q   = 9'b001000000,
		S_CALC_R   = 9'b010000000,
		S_FIN_ADDR = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_ACQUIRE: begin
						if (sts.num_zero) begin
							cmd.finish = 1'b1;
							cmd.status = ST_NULL;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_RELEASE, OP_SYNC: begin
						if (sts.si_bad) begin
							cmd.finish = 1'b1;
							cmd.status = ST_UNUSED;
							state_d    = S_IDLE;
						end else begin
							state_d = S_FETCH;
						end
					end
					OP_NONE: begin
						cmd.finish = 1'b1;
						cmd.status = ST_DONE;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			// last compare lands at the end of this cycle
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (sts.hit_found) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
					if (sts.hit_at_max) begin
						cmd.status = ST_LIMIT;
					end else begin
						cmd.mem_wr = 1'b1;
						cmd.status = ST_DONE;
					end
				end else if (!sts.free_found) begin
					cmd.finish = 1'b1;
					cmd.status = ST_FULL;
					state_d    = S_IDLE;
				end else if (!sts.dev_root) begin
					cmd.finish = 1'b1;
					cmd.status = ST_UNKNOWN_DEV;
					state_d    = S_IDLE;
				end else begin
					cmd.mem_wr = 1'b1;
					state_d    = S_CALC_Q;
				end
			end
			S_FETCH: begin
				priority if (sts.op == OP_RELEASE) begin
					cmd.mem_wr = 1'b1;
					cmd.finish = 1'b1;
					cmd.status = ST_DONE;
					state_d    = S_IDLE;
				end else if (!sts.dev_root) begin
					cmd.finish = 1'b1;
					cmd.status = ST_UNKNOWN_DEV;
					state_d    = S_IDLE;
				end else begin
					state_d = S_CALC_Q;
				end
			end
			S_CALC_Q: begin
				cmd.calc_q = 1'b1;
				state_d    = S_CALC_R;
			end
			S_CALC_R: begin
				cmd.calc_r = 1'b1;
				state_d    = S_FIN_ADDR;
			end
			S_FIN_ADDR: begin
				cmd.finish = 1'b1;
				cmd.status = (sts.op == OP_ACQUIRE) ? ST_FETCH : ST_DONE;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/icrt_dp.sv @@
`default_nettype none
module icrt_dp
	import icrt_pkg::*;
#(
	parameter int TABLE_SLOTS       = DEF_TABLE_SLOTS,
	parameter int INODES_PER_SECTOR = DEF_INODES_PER_SECTOR,
	parameter int INODE_BYTES       = DEF_INODE_BYTES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic [OP_W-1:0]      operation,
	input  wire logic [DEV_W-1:0]     device,
	input  wire logic [INO_W-1:0]     inode_number,
	input  wire logic [SLOT_W-1:0]    slot_index,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output logic                      done,
	output logic [STAT_W-1:0]         status,
	output logic [SLOT_W-1:0]         slot,
	output logic [SEC_W-1:0]          sector_number,
	output logic [BOFF_W-1:0]         byte_offset,
	output logic [CNT_W-1:0]          reference_count
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int REM_W = (INODES_PER_SECTOR > 1) ? $clog2(INODES_PER_SECTOR) : 1;
	// x / INODES_PER_SECTOR as (x * RECIP) >> RECIP_SHIFT, exact for 12-bit x
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W = RECIP_SHIFT + 1;
	localparam int PROD_W = INO_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((1 << RECIP_SHIFT) / INODES_PER_SECTOR + 1);

	// configuration
	logic [DEV_W-1:0] root_dev_q;
	logic [IMS_W-1:0] ims_q;
	logic [SMS_W-1:0] sms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_dev_q <= '0;
			ims_q      <= IMS_W'(1);
			sms_q      <= SMS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROOT_DEVICE: root_dev_q <= cfg_data;
				CFG_INODE_MAP:   ims_q      <= cfg_data[IMS_W-1:0];
				CFG_SECTOR_MAP:  sms_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// request context
	op_t               op_q;
	logic [DEV_W-1:0]  dev_q;
	logic [INO_W-1:0]  num_q;
	logic [SLOT_W-1:0] si_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(operation);
			dev_q <= device;
			num_q <= inode_number;
			si_q  <= slot_index;
		end
	end

	logic             si_in_range;
	logic [IDX_W-1:0] si_idx;

	assign si_in_range = (32'(si_q) < TABLE_SLOTS);
	assign si_idx      = IDX_W'(si_q);

	// slot table: used bits in flops, entries in a memory
	logic [TABLE_SLOTS-1:0] used_q;
	entry_t                 mem [TABLE_SLOTS];
	entry_t                 rd_q;
	logic [IDX_W-1:0]       rd_idx;
	logic [IDX_W-1:0]       wr_idx;
	entry_t                 wr_entry;

	// scan pointer and compare stage
	logic [IDX_W-1:0] scan_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	assign rd_idx = (op_q == OP_ACQUIRE) ? scan_idx_q : si_idx;

	always_comb begin
		if (op_q == OP_ACQUIRE) begin
			if (hit_found_q) begin
				wr_idx   = hit_idx_q;
				wr_entry = '{dev: dev_q, inode: num_q, cnt: hit_cnt_q + CNT_W'(1)};
			end else begin
				wr_idx   = free_idx_q;
				wr_entry = '{dev: dev_q, inode: num_q, cnt: CNT_W'(1)};
			end
		end else begin
			wr_idx   = si_idx;
			wr_entry = '{dev: rd_q.dev, inode: rd_q.inode, cnt: rd_q.cnt - CNT_W'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[wr_idx] <= wr_entry;
		end
		rd_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.mem_wr) begin
			if (op_q == OP_ACQUIRE && !hit_found_q) begin
				used_q[free_idx_q] <= 1'b1;
			end else if (op_q == OP_RELEASE && rd_q.cnt == CNT_W'(1)) begin
				used_q[si_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			vld_s1       <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_step;
			if (cmd.load) begin
				scan_idx_q   <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				if (vld_s1) begin
					if (used_q[idx_s1]) begin
						if (!hit_found_q && rd_q.dev == dev_q && rd_q.inode == num_q) begin
							hit_found_q <= 1'b1;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (vld_s1) begin
			if (used_q[idx_s1]) begin
				if (!hit_found_q && rd_q.dev == dev_q && rd_q.inode == num_q) begin
					hit_idx_q <= idx_s1;
					hit_cnt_q <= rd_q.cnt;
				end
			end else if (!free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// inode address: quotient, then remainder, then sum and offset
	logic [INO_W-1:0]  x_d;
	logic [INO_W-1:0]  x_q;
	logic [PROD_W-1:0] prod;
	logic [INO_W-1:0]  q_q;
	logic [INO_W-1:0]  qd;
	logic [INO_W-1:0]  r_full;
	logic [REM_W-1:0]  r_q;
	logic [SEC_W-1:0]  sector_d;
	logic [BOFF_W-1:0] offset_d;

	assign x_d    = ((op_q == OP_ACQUIRE) ? num_q : rd_q.inode) - INO_W'(1);
	assign prod   = PROD_W'(x_d) * PROD_W'(RECIP);
	assign qd     = INO_W'(32'(q_q) * INODES_PER_SECTOR);
	assign r_full = x_q - qd;

	always_ff @(posedge clk) begin
		if (cmd.calc_q) begin
			x_q <= x_d;
			q_q <= INO_W'(prod >> RECIP_SHIFT);
		end
		if (cmd.calc_r) begin
			r_q <= REM_W'(r_full);
		end
	end

	assign sector_d = SEC_W'(32'(BOOT_SECTORS) + 32'(ims_q) + 32'(sms_q) + 32'(q_q));
	assign offset_d = BOFF_W'(32'(r_q) * INODE_BYTES);

	// result beat
	logic              done_q;
	logic [STAT_W-1:0] res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [SEC_W-1:0]  res_sector_q;
	logic [BOFF_W-1:0] res_offset_q;
	logic [CNT_W-1:0]  res_count_q;
	logic [SLOT_W-1:0] slot_d;
	logic [CNT_W-1:0]  count_d;
	logic              addr_d;

	always_comb begin
		slot_d  = '0;
		count_d = '0;
		addr_d  = 1'b0;
		unique case (op_q)
			OP_ACQUIRE: begin
				if (cmd.status == ST_DONE) begin
					slot_d  = SLOT_W'(hit_idx_q);
					count_d = hit_cnt_q + CNT_W'(1);
				end else if (cmd.status == ST_LIMIT) begin
					slot_d  = SLOT_W'(hit_idx_q);
					count_d = hit_cnt_q;
				end else if (cmd.status == ST_FETCH) begin
					slot_d  = SLOT_W'(free_idx_q);
					count_d = CNT_W'(1);
					addr_d  = 1'b1;
				end
			end
			OP_RELEASE: begin
				slot_d = si_q;
				if (cmd.status == ST_DONE) begin
					count_d = rd_q.cnt - CNT_W'(1);
				end
			end
			OP_SYNC: begin
				slot_d = si_q;
				if (cmd.status == ST_DONE || cmd.status == ST_UNKNOWN_DEV) begin
					count_d = rd_q.cnt;
				end
				addr_d = (cmd.status == ST_DONE);
			end
			OP_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status_q <= cmd.status;
			res_slot_q   <= slot_d;
			res_count_q  <= count_d;
			res_sector_q <= addr_d ? sector_d : '0;
			res_offset_q <= addr_d ? offset_d : '0;
		end
	end

	assign done            = done_q;
	assign status          = res_status_q;
	assign slot            = res_slot_q;
	assign sector_number   = res_sector_q;
	assign byte_offset     = res_offset_q;
	assign reference_count = res_count_q;

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.num_zero   = (num_q == '0);
		sts.si_bad     = si_in_range ? !used_q[si_idx] : 1'b1;
		sts.scan_last  = (scan_idx_q == IDX_W'(TABLE_SLOTS - 1));
		sts.hit_found  = hit_found_q;
		sts.hit_at_max = (hit_cnt_q == CNT_MAX);
		sts.free_found = free_found_q;
		sts.dev_root   = (op_q == OP_ACQUIRE) ? (dev_q == root_dev_q)
		                                      : (rd_q.dev == root_dev_q);
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result beat lasted more than one cycle");

	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr && op_q == OP_ACQUIRE && !hit_found_q
			|-> free_found_q && !used_q[free_idx_q])
		else $error("claim targets a slot already in use");

	a_hit_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr && op_q == OP_ACQUIRE && hit_found_q |-> hit_cnt_q != CNT_MAX)
		else $error("reference count would wrap");

	a_release_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr && op_q == OP_RELEASE |-> si_in_range && used_q[si_idx])
		else $error("release writes an unused slot");

endmodule
`default_nettype wire

@@ hdl/inode_cache_refcount_table.sv @@
// inode slot table with reference counts
//
// command channel: drive operation, device, inode_number and slot_index with
// start; the beat is taken at a clock edge where start is high and busy is low.
// busy stays high until the result has been registered.
// result channel: done is high for exactly one cycle and status, slot,
// sector_number, byte_offset and reference_count are valid in that cycle.
// the receiver cannot stall; done drops after that cycle.
// config channel: cfg_valid with cfg_index and cfg_data, cfg_ready always high;
// write only while busy is low and no result is pending.
// acquire passes dispatch, the slot scan, a scan end and a decide step on a
// hit, full table or unknown device, plus a divide, a remainder and an address
// step when a slot is claimed; the scan reads one table entry per cycle through
// the single memory read port. release passes dispatch and fetch; sync adds the
// address steps on the root device; null inode, unused slot end at dispatch.
// a new command is accepted in the cycle done is shown.
// reset clears all slot valid bits at once, so no clearing pass is needed,
// and sets root_device 0, inode_map_sectors 1, sector_map_sectors 1.
`default_nettype none
module inode_cache_refcount_table
	import icrt_pkg::*;
#(
	parameter int TABLE_SLOTS       = DEF_TABLE_SLOTS,
	parameter int INODES_PER_SECTOR = DEF_INODES_PER_SECTOR,
	parameter int INODE_BYTES       = DEF_INODE_BYTES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [OP_W-1:0]      operation,
	input  wire logic [DEV_W-1:0]     device,
	input  wire logic [INO_W-1:0]     inode_number,
	input  wire logic [SLOT_W-1:0]    slot_index,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output logic                      done,
	output logic [STAT_W-1:0]         status,
	output logic [SLOT_W-1:0]         slot,
	output logic [SEC_W-1:0]          sector_number,
	output logic [BOFF_W-1:0]         byte_offset,
	output logic [CNT_W-1:0]          reference_count
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	icrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	icrt_dp #(
		.TABLE_SLOTS       (TABLE_SLOTS),
		.INODES_PER_SECTOR (INODES_PER_SECTOR),
		.INODE_BYTES       (INODE_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.device          (device),
		.inode_number    (inode_number),
		.slot_index      (slot_index),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.status          (status),
		.slot            (slot),
		.sector_number   (sector_number),
		.byte_offset     (byte_offset),
		.reference_count (reference_count)
	);

endmodule
`default_nettype wire
